// ----- rtl/core/irc_line_tokenizer_defines.svh -----
// Assertion macros shared by the tokenizer RTL.
`ifndef IRC_LINE_TOKENIZER_DEFINES_SVH
`define IRC_LINE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS

`define IRCLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define IRCLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define IRCLT_ASSERT(lbl, clk, rst_n, prop, msg)

`define IRCLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/irclt_pkg.sv -----
// Types, character codes and helper functions of the IRC line tokenizer.
package irclt_pkg;

    localparam int DEF_MAX_TAGS   = 32;
    localparam int DEF_MAX_PARAMS = 15;

    // Output word queue depth; the input is taken only with two slots free.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Internal field index width, wide enough for indices up to 255; the output word keeps five bits.
    localparam int IDX_W = 8;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    localparam logic [2:0] KIND_TAG_KEY  = 3'd0;
    localparam logic [2:0] KIND_TAG_VAL  = 3'd1;
    localparam logic [2:0] KIND_PREFIX   = 3'd2;
    localparam logic [2:0] KIND_COMMAND  = 3'd3;
    localparam logic [2:0] KIND_MIDDLE   = 3'd4;
    localparam logic [2:0] KIND_TRAILING = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_SATURATE = 2'd2;

    typedef enum logic [13:0] {
        PH_START       = 14'b00000000000001,
        PH_TAG_GAP     = 14'b00000000000010,
        PH_TAG_KEY     = 14'b00000000000100,
        PH_TAG_VAL     = 14'b00000000001000,
        PH_TAG_SKIP    = 14'b00000000010000,
        PH_PRE_SPACE   = 14'b00000000100000,
        PH_PREFIX      = 14'b00000001000000,
        PH_CMD_START   = 14'b00000010000000,
        PH_CMD         = 14'b00000100000000,
        PH_PARAM_GAP   = 14'b00001000000000,
        PH_MIDDLE      = 14'b00010000000000,
        PH_MIDDLE_SKIP = 14'b00100000000000,
        PH_TRAILING    = 14'b01000000000000,
        PH_IGNORE      = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_kind;
        logic [4:0] field_index;
        logic       field_start;
        logic       line_done;
        logic [5:0] tags_found;
        logic [3:0] params_found;
        logic       trailing_seen;
        logic [1:0] status;
    } t_result;

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_LOW_A && b <= CH_LOW_Z) begin
            r = b - CASE_GAP;
        end
        return r;
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_COLON: r = CH_SEMI;
            CH_S:     r = CH_SPACE;
            CH_R:     r = CH_CR;
            CH_N:     r = CH_LF;
            default:  r = b;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/irc_line_tokenizer.sv -----
// IRC line tokenizer: labels each byte of a message line and closes it with a summary word.
//
//   Channel | Handshake                    | Words
//   --------+------------------------------+---------------------------------------------
//   input   | i_in_valid / o_in_stall      | i_in_byte, i_end_of_line
//   output  | o_out_valid / i_out_stall    | o_out_byte ... o_status (byte or summary)
//
// One input byte is taken every cycle while the input is not stalled; the state update is done in the accepting cycle.
// A byte yields up to two output words (a labeled byte plus the end-of-line summary),
// which go into a four-word output queue.
// Input is stalled while fewer than two queue slots are free.
// Reset is synchronous and returns the parser to line start with an empty queue.
`include "irc_line_tokenizer_defines.svh"

module irc_line_tokenizer #(
    parameter int MAX_TAGS   = irclt_pkg::DEF_MAX_TAGS,
    parameter int MAX_PARAMS = irclt_pkg::DEF_MAX_PARAMS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_line,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_field_kind,
    output logic [4:0] o_field_index,
    output logic       o_field_start,
    output logic       o_line_done,
    output logic [5:0] o_tags_found,
    output logic [3:0] o_params_found,
    output logic       o_trailing_seen,
    output logic [1:0] o_status
);

    localparam int TW = $clog2(MAX_TAGS + 1);
    localparam int PW = $clog2(MAX_PARAMS + 1);

    irclt_pkg::t_phase r_phase, n_phase;
    logic              r_esc, n_esc;
    logic              r_fresh, n_fresh;
    logic [TW-1:0]     r_tag, n_tag;
    logic [PW-1:0]     r_param, n_param;
    logic              r_trail, n_trail;
    logic              r_ovf, n_ovf;

    irclt_pkg::t_result            r_mem [irclt_pkg::Q_DEPTH];
    logic [irclt_pkg::Q_PTR_W-1:0] r_wr, r_rd;
    logic [irclt_pkg::Q_CNT_W-1:0] r_count, n_count;

    logic                      in_acc, out_acc;
    logic                      p_vld, p_start;
    logic [7:0]                p_byte;
    logic [2:0]                p_kind;
    logic [irclt_pkg::IDX_W-1:0] p_idx;
    logic [TW-1:0]             ti;
    logic [PW-1:0]             pi;
    logic                      tag_full, param_full, is_crlf, in_tags;
    irclt_pkg::t_result        byte_res, sum_res, e0, e1;
    logic [1:0]                push;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = o_out_valid && !i_out_stall;
    assign o_in_stall = r_count > irclt_pkg::Q_CNT_W'(irclt_pkg::Q_DEPTH - 2);
    assign o_out_valid = r_count != '0;

    assign ti         = (r_tag != '0) ? r_tag - 1'b1 : '0;
    assign pi         = (r_param != '0) ? r_param - 1'b1 : '0;
    assign tag_full   = r_tag >= TW'(MAX_TAGS);
    assign param_full = r_param >= PW'(MAX_PARAMS);
    assign is_crlf    = i_in_byte == irclt_pkg::CH_CR || i_in_byte == irclt_pkg::CH_LF;

    // Next parser state and the byte word, if any, for the byte at the input.
    always_comb begin
        logic fr;
        logic done;
        n_phase = r_phase;
        n_esc   = r_esc;
        n_tag   = r_tag;
        n_param = r_param;
        n_trail = r_trail;
        n_ovf   = r_ovf;
        fr      = r_fresh;
        done    = 1'b0;
        p_vld   = 1'b0;
        p_byte  = '0;
        p_kind  = irclt_pkg::KIND_TAG_KEY;
        p_idx   = '0;
        p_start = 1'b0;
        if (!is_crlf) begin
            unique case (r_phase)
                irclt_pkg::PH_START: begin
                    if (i_in_byte == irclt_pkg::CH_AT) begin
                        n_phase = irclt_pkg::PH_TAG_GAP;
                    end else if (i_in_byte == irclt_pkg::CH_COLON) begin
                        fr = 1'b1;
                        n_phase = irclt_pkg::PH_PREFIX;
                    end else if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_PARAM_GAP;
                    end else begin
                        p_vld = 1'b1; p_byte = irclt_pkg::to_upper(i_in_byte);
                        p_kind = irclt_pkg::KIND_COMMAND; p_start = 1'b1; fr = 1'b0;
                        n_phase = irclt_pkg::PH_CMD;
                    end
                end
                irclt_pkg::PH_TAG_GAP: begin
                    if (i_in_byte == irclt_pkg::CH_SEMI) begin
                        n_phase = r_phase;
                    end else if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_PRE_SPACE;
                    end else if (tag_full) begin
                        n_ovf = 1'b1;
                        n_phase = irclt_pkg::PH_TAG_SKIP;
                    end else begin
                        n_tag = r_tag + 1'b1;
                        fr = 1'b1;
                        if (i_in_byte == irclt_pkg::CH_EQUAL) begin
                            n_phase = irclt_pkg::PH_TAG_VAL;
                        end else begin
                            p_vld = 1'b1; p_byte = i_in_byte;
                            p_kind = irclt_pkg::KIND_TAG_KEY;
                            p_idx = irclt_pkg::IDX_W'(r_tag); p_start = fr; fr = 1'b0;
                            n_phase = irclt_pkg::PH_TAG_KEY;
                        end
                    end
                end
                irclt_pkg::PH_TAG_KEY: begin
                    if (i_in_byte == irclt_pkg::CH_SEMI) begin
                        n_phase = irclt_pkg::PH_TAG_GAP;
                    end else if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_PRE_SPACE;
                    end else if (i_in_byte == irclt_pkg::CH_EQUAL) begin
                        fr = 1'b1;
                        n_phase = irclt_pkg::PH_TAG_VAL;
                    end else begin
                        p_vld = 1'b1; p_byte = i_in_byte;
                        p_kind = irclt_pkg::KIND_TAG_KEY;
                        p_idx = irclt_pkg::IDX_W'(ti); p_start = fr; fr = 1'b0;
                    end
                end
                irclt_pkg::PH_TAG_VAL: begin
                    p_kind = irclt_pkg::KIND_TAG_VAL;
                    p_idx  = irclt_pkg::IDX_W'(ti);
                    if (r_esc) begin
                        n_esc = 1'b0;
                        p_vld = 1'b1; p_start = fr; fr = 1'b0;
                        // A backslash before a separator is kept literally.
                        if (i_in_byte != irclt_pkg::CH_SEMI &&
                            i_in_byte != irclt_pkg::CH_SPACE) begin
                            p_byte = irclt_pkg::unescape(i_in_byte);
                            done = 1'b1;
                        end else begin
                            p_byte = irclt_pkg::CH_BSLASH;
                        end
                    end
                    if (!done) begin
                        if (i_in_byte == irclt_pkg::CH_BSLASH) begin
                            n_esc = 1'b1;
                        end else if (i_in_byte == irclt_pkg::CH_SEMI) begin
                            n_phase = irclt_pkg::PH_TAG_GAP;
                        end else if (i_in_byte == irclt_pkg::CH_SPACE) begin
                            n_phase = irclt_pkg::PH_PRE_SPACE;
                        end else begin
                            p_vld = 1'b1; p_byte = i_in_byte; p_start = fr; fr = 1'b0;
                        end
                    end
                end
                irclt_pkg::PH_TAG_SKIP: begin
                    if (i_in_byte == irclt_pkg::CH_SEMI) begin
                        n_phase = irclt_pkg::PH_TAG_GAP;
                    end else if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_PRE_SPACE;
                    end
                end
                irclt_pkg::PH_PRE_SPACE: begin
                    if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = r_phase;
                    end else if (i_in_byte == irclt_pkg::CH_COLON) begin
                        fr = 1'b1;
                        n_phase = irclt_pkg::PH_PREFIX;
                    end else begin
                        p_vld = 1'b1; p_byte = irclt_pkg::to_upper(i_in_byte);
                        p_kind = irclt_pkg::KIND_COMMAND; p_start = 1'b1; fr = 1'b0;
                        n_phase = irclt_pkg::PH_CMD;
                    end
                end
                irclt_pkg::PH_PREFIX: begin
                    if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_CMD_START;
                    end else begin
                        p_vld = 1'b1; p_byte = i_in_byte;
                        p_kind = irclt_pkg::KIND_PREFIX; p_start = fr; fr = 1'b0;
                    end
                end
                irclt_pkg::PH_CMD_START: begin
                    if (i_in_byte != irclt_pkg::CH_SPACE) begin
                        p_vld = 1'b1; p_byte = irclt_pkg::to_upper(i_in_byte);
                        p_kind = irclt_pkg::KIND_COMMAND; p_start = 1'b1; fr = 1'b0;
                        n_phase = irclt_pkg::PH_CMD;
                    end
                end
                irclt_pkg::PH_CMD: begin
                    if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_PARAM_GAP;
                    end else begin
                        p_vld = 1'b1; p_byte = irclt_pkg::to_upper(i_in_byte);
                        p_kind = irclt_pkg::KIND_COMMAND; p_start = fr; fr = 1'b0;
                    end
                end
                irclt_pkg::PH_PARAM_GAP: begin
                    if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = r_phase;
                    end else if (i_in_byte == irclt_pkg::CH_COLON) begin
                        // A dropped trailing parameter still counts as seen.
                        n_trail = 1'b1;
                        if (param_full) begin
                            n_ovf = 1'b1;
                            n_phase = irclt_pkg::PH_IGNORE;
                        end else begin
                            n_param = r_param + 1'b1;
                            fr = 1'b1;
                            n_phase = irclt_pkg::PH_TRAILING;
                        end
                    end else if (param_full) begin
                        n_ovf = 1'b1;
                        n_phase = irclt_pkg::PH_MIDDLE_SKIP;
                    end else begin
                        n_param = r_param + 1'b1;
                        p_vld = 1'b1; p_byte = i_in_byte;
                        p_kind = irclt_pkg::KIND_MIDDLE;
                        p_idx = irclt_pkg::IDX_W'(r_param); p_start = 1'b1; fr = 1'b0;
                        n_phase = irclt_pkg::PH_MIDDLE;
                    end
                end
                irclt_pkg::PH_MIDDLE: begin
                    if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_PARAM_GAP;
                    end else begin
                        p_vld = 1'b1; p_byte = i_in_byte;
                        p_kind = irclt_pkg::KIND_MIDDLE;
                        p_idx = irclt_pkg::IDX_W'(pi); p_start = fr; fr = 1'b0;
                    end
                end
                irclt_pkg::PH_MIDDLE_SKIP: begin
                    if (i_in_byte == irclt_pkg::CH_SPACE) begin
                        n_phase = irclt_pkg::PH_PARAM_GAP;
                    end
                end
                irclt_pkg::PH_TRAILING: begin
                    p_vld = 1'b1; p_byte = i_in_byte;
                    p_kind = irclt_pkg::KIND_TRAILING;
                    p_idx = irclt_pkg::IDX_W'(pi); p_start = fr; fr = 1'b0;
                end
                irclt_pkg::PH_IGNORE: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        // A backslash left open at end of line is emitted literally. It never
        // coincides with a byte word from the same input byte.
        if (i_end_of_line && n_phase == irclt_pkg::PH_TAG_VAL && n_esc) begin
            p_vld = 1'b1; p_byte = irclt_pkg::CH_BSLASH;
            p_kind = irclt_pkg::KIND_TAG_VAL;
            p_idx = irclt_pkg::IDX_W'(ti); p_start = fr; fr = 1'b0;
            n_esc = 1'b0;
        end
        n_fresh = fr;
    end

    assign in_tags = n_phase == irclt_pkg::PH_TAG_GAP || n_phase == irclt_pkg::PH_TAG_KEY ||
                     n_phase == irclt_pkg::PH_TAG_VAL || n_phase == irclt_pkg::PH_TAG_SKIP;

    always_comb begin
        byte_res = '0;
        byte_res.out_byte    = p_byte;
        byte_res.field_kind  = p_kind;
        byte_res.field_index = p_idx[4:0];
        byte_res.field_start = p_start;

        sum_res = '0;
        sum_res.line_done = 1'b1;
        if (in_tags) begin
            sum_res.status = irclt_pkg::ST_NO_SPACE;
        end else begin
            sum_res.tags_found    = 6'(n_tag);
            sum_res.params_found  = 4'(n_param);
            sum_res.trailing_seen = n_trail;
            sum_res.status        = n_ovf ? irclt_pkg::ST_SATURATE : irclt_pkg::ST_OK;
        end

        if (p_vld) begin
            e0   = byte_res;
            e1   = sum_res;
            push = i_end_of_line ? 2'd2 : 2'd1;
        end else begin
            e0   = sum_res;
            e1   = sum_res;
            push = i_end_of_line ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + irclt_pkg::Q_CNT_W'(push);
        end
        if (out_acc) begin
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= irclt_pkg::PH_START;
            r_esc   <= 1'b0;
            r_fresh <= 1'b1;
            r_tag   <= '0;
            r_param <= '0;
            r_trail <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (in_acc) begin
            if (i_end_of_line) begin
                r_phase <= irclt_pkg::PH_START;
                r_esc   <= 1'b0;
                r_fresh <= 1'b1;
                r_tag   <= '0;
                r_param <= '0;
                r_trail <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_esc   <= n_esc;
                r_fresh <= n_fresh;
                r_tag   <= n_tag;
                r_param <= n_param;
                r_trail <= n_trail;
                r_ovf   <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (in_acc) begin
                r_wr <= r_wr + irclt_pkg::Q_PTR_W'(push);
            end
            if (out_acc) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && push != 2'd0) begin
            r_mem[r_wr] <= e0;
        end
        if (in_acc && push == 2'd2) begin
            r_mem[r_wr + 1'b1] <= e1;
        end
    end

    assign o_out_byte      = r_mem[r_rd].out_byte;
    assign o_field_kind    = r_mem[r_rd].field_kind;
    assign o_field_index   = r_mem[r_rd].field_index;
    assign o_field_start   = r_mem[r_rd].field_start;
    assign o_line_done     = r_mem[r_rd].line_done;
    assign o_tags_found    = r_mem[r_rd].tags_found;
    assign o_params_found  = r_mem[r_rd].params_found;
    assign o_trailing_seen = r_mem[r_rd].trailing_seen;
    assign o_status        = r_mem[r_rd].status;

    `IRCLT_ASSERT(a_queue_bound, i_clk, i_rst_n, r_count <= irclt_pkg::Q_CNT_W'(irclt_pkg::Q_DEPTH), "output queue count exceeds its depth")
    `IRCLT_ASSERT(a_esc_in_value, i_clk, i_rst_n, !r_esc || r_phase == irclt_pkg::PH_TAG_VAL, "escape pending outside a tag value")
    `IRCLT_ASSERT(a_tag_bound, i_clk, i_rst_n, r_tag <= TW'(MAX_TAGS), "tag count beyond its limit")
    `IRCLT_ASSERT(a_param_bound, i_clk, i_rst_n, r_param <= PW'(MAX_PARAMS), "parameter count beyond its limit")
    `IRCLT_ASSERT_NEXT(a_eol_clears, i_clk, i_rst_n, in_acc && i_end_of_line, r_phase == irclt_pkg::PH_START && r_tag == '0 && r_param == '0, "line state not cleared after end of line")

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the IRC line tokenizer: random and directed lines, scored per word.
`timescale 1ns / 1ps

module testbench;

    localparam int TAG_LIMIT   = irclt_pkg::DEF_MAX_TAGS;
    localparam int PARAM_LIMIT = irclt_pkg::DEF_MAX_PARAMS;
    localparam int BYTE_TARGET = 1700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET_LO    = 700;
    localparam int QUIET_HI    = 1200;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 200;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_Q    = 8'h51;

    typedef enum int {
        FLAVOR_PLAIN,
        FLAVOR_VALUE,
        FLAVOR_TRAIL
    } t_flavor;

    typedef struct {
        logic [7:0] data;
        logic       eol;
    } t_line_byte;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic [7:0] in_byte = '0;
    logic       in_eol = 1'b0;
    logic       out_stall = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [2:0] field_kind;
    logic [4:0] field_index;
    logic       field_start;
    logic       line_done;
    logic [5:0] tags_found;
    logic [3:0] params_found;
    logic       trailing_seen;
    logic [1:0] status;

    t_line_byte         line_bytes[$];
    irclt_pkg::t_result expected_words[$];
    int                 cycle_count = 0;
    int                 errors = 0;
    logic               in_taken = 1'b0;
    int                 hold_left = 0;
    logic               hold_done = 1'b0;

    // Shadow copy of the parser state.
    irclt_pkg::t_phase ph = irclt_pkg::PH_START;
    logic   esc_pend = 1'b0;
    logic   fresh = 1'b1;
    int     tag_cnt = 0;
    int     par_cnt = 0;
    logic   trail_f = 1'b0;
    logic   ovf_f = 1'b0;

    irc_line_tokenizer dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_in_byte      (in_byte),
        .i_end_of_line  (in_eol),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_out_byte     (out_byte),
        .o_field_kind   (field_kind),
        .o_field_index  (field_index),
        .o_field_start  (field_start),
        .o_line_done    (line_done),
        .o_tags_found   (tags_found),
        .o_params_found (params_found),
        .o_trailing_seen(trailing_seen),
        .o_status       (status)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] capital_of(input logic [7:0] b);
        return (b >= irclt_pkg::CH_LOW_A && b <= irclt_pkg::CH_LOW_Z) ?
               b - irclt_pkg::CASE_GAP : b;
    endfunction

    function automatic logic [7:0] escaped_char(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b == irclt_pkg::CH_COLON) c = irclt_pkg::CH_SEMI;
        else if (b == irclt_pkg::CH_S) c = irclt_pkg::CH_SPACE;
        else if (b == irclt_pkg::CH_R) c = irclt_pkg::CH_CR;
        else if (b == irclt_pkg::CH_N) c = irclt_pkg::CH_LF;
        return c;
    endfunction

    function automatic logic open_tag();
        if (tag_cnt >= TAG_LIMIT) begin
            ovf_f = 1'b1;
            return 1'b0;
        end
        tag_cnt++;
        fresh = 1'b1;
        return 1'b1;
    endfunction

    function automatic logic open_param();
        if (par_cnt >= PARAM_LIMIT) begin
            ovf_f = 1'b1;
            return 1'b0;
        end
        par_cnt++;
        fresh = 1'b1;
        return 1'b1;
    endfunction

    task automatic emit_byte(input logic [7:0] b, input logic [2:0] kind, input int idx);
        irclt_pkg::t_result r;
        r = '0;
        r.out_byte    = b;
        r.field_kind  = kind;
        r.field_index = idx[4:0];
        r.field_start = fresh;
        fresh = 1'b0;
        expected_words.push_back(r);
    endtask

    task automatic begin_command(input logic [7:0] b);
        fresh = 1'b1;
        emit_byte(capital_of(b), irclt_pkg::KIND_COMMAND, 0);
        ph = irclt_pkg::PH_CMD;
    endtask

    // Works out the words that one accepted input byte produces.
    task automatic predict_words(input logic [7:0] b, input logic eol);
        int     ti;
        int     pi;
        logic   handled;
        logic   in_tags;
        irclt_pkg::t_result r;
        ti = (tag_cnt != 0) ? tag_cnt - 1 : 0;
        pi = (par_cnt != 0) ? par_cnt - 1 : 0;
        handled = 1'b0;
        if (b != irclt_pkg::CH_CR && b != irclt_pkg::CH_LF) begin
            case (ph)
                irclt_pkg::PH_START: begin
                    if (b == irclt_pkg::CH_AT) ph = irclt_pkg::PH_TAG_GAP;
                    else if (b == irclt_pkg::CH_COLON) begin
                        fresh = 1'b1;
                        ph = irclt_pkg::PH_PREFIX;
                    end else if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PARAM_GAP;
                    else begin_command(b);
                end
                irclt_pkg::PH_TAG_GAP: begin
                    if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PRE_SPACE;
                    else if (b != irclt_pkg::CH_SEMI) begin
                        if (!open_tag()) ph = irclt_pkg::PH_TAG_SKIP;
                        else if (b == irclt_pkg::CH_EQUAL) ph = irclt_pkg::PH_TAG_VAL;
                        else begin
                            emit_byte(b, irclt_pkg::KIND_TAG_KEY, tag_cnt - 1);
                            ph = irclt_pkg::PH_TAG_KEY;
                        end
                    end
                end
                irclt_pkg::PH_TAG_KEY: begin
                    if (b == irclt_pkg::CH_SEMI) ph = irclt_pkg::PH_TAG_GAP;
                    else if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PRE_SPACE;
                    else if (b == irclt_pkg::CH_EQUAL) begin
                        fresh = 1'b1;
                        ph = irclt_pkg::PH_TAG_VAL;
                    end else emit_byte(b, irclt_pkg::KIND_TAG_KEY, ti);
                end
                irclt_pkg::PH_TAG_VAL: begin
                    if (esc_pend) begin
                        esc_pend = 1'b0;
                        if (b != irclt_pkg::CH_SEMI && b != irclt_pkg::CH_SPACE) begin
                            emit_byte(escaped_char(b), irclt_pkg::KIND_TAG_VAL, ti);
                            handled = 1'b1;
                        end else begin
                            // A backslash that ends the value is kept as it is.
                            emit_byte(irclt_pkg::CH_BSLASH, irclt_pkg::KIND_TAG_VAL, ti);
                        end
                    end
                    if (!handled) begin
                        if (b == irclt_pkg::CH_BSLASH) esc_pend = 1'b1;
                        else if (b == irclt_pkg::CH_SEMI) ph = irclt_pkg::PH_TAG_GAP;
                        else if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PRE_SPACE;
                        else emit_byte(b, irclt_pkg::KIND_TAG_VAL, ti);
                    end
                end
                irclt_pkg::PH_TAG_SKIP: begin
                    if (b == irclt_pkg::CH_SEMI) ph = irclt_pkg::PH_TAG_GAP;
                    else if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PRE_SPACE;
                end
                irclt_pkg::PH_PRE_SPACE: begin
                    if (b == irclt_pkg::CH_COLON) begin
                        fresh = 1'b1;
                        ph = irclt_pkg::PH_PREFIX;
                    end else if (b != irclt_pkg::CH_SPACE) begin_command(b);
                end
                irclt_pkg::PH_PREFIX: begin
                    if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_CMD_START;
                    else emit_byte(b, irclt_pkg::KIND_PREFIX, 0);
                end
                irclt_pkg::PH_CMD_START: begin
                    if (b != irclt_pkg::CH_SPACE) begin_command(b);
                end
                irclt_pkg::PH_CMD: begin
                    if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PARAM_GAP;
                    else emit_byte(capital_of(b), irclt_pkg::KIND_COMMAND, 0);
                end
                irclt_pkg::PH_PARAM_GAP: begin
                    if (b == irclt_pkg::CH_COLON) begin
                        trail_f = 1'b1;
                        ph = open_param() ? irclt_pkg::PH_TRAILING : irclt_pkg::PH_IGNORE;
                    end else if (b != irclt_pkg::CH_SPACE) begin
                        if (open_param()) begin
                            emit_byte(b, irclt_pkg::KIND_MIDDLE, par_cnt - 1);
                            ph = irclt_pkg::PH_MIDDLE;
                        end else ph = irclt_pkg::PH_MIDDLE_SKIP;
                    end
                end
                irclt_pkg::PH_MIDDLE: begin
                    if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PARAM_GAP;
                    else emit_byte(b, irclt_pkg::KIND_MIDDLE, pi);
                end
                irclt_pkg::PH_MIDDLE_SKIP: begin
                    if (b == irclt_pkg::CH_SPACE) ph = irclt_pkg::PH_PARAM_GAP;
                end
                irclt_pkg::PH_TRAILING: begin
                    emit_byte(b, irclt_pkg::KIND_TRAILING, pi);
                end
                default: begin
                end
            endcase
        end
        if (eol) begin
            if (ph == irclt_pkg::PH_TAG_VAL && esc_pend) begin
                esc_pend = 1'b0;
                emit_byte(irclt_pkg::CH_BSLASH, irclt_pkg::KIND_TAG_VAL,
                          (tag_cnt != 0) ? tag_cnt - 1 : 0);
            end
            in_tags = (ph == irclt_pkg::PH_TAG_GAP) || (ph == irclt_pkg::PH_TAG_KEY) ||
                      (ph == irclt_pkg::PH_TAG_VAL) || (ph == irclt_pkg::PH_TAG_SKIP);
            r = '0;
            r.line_done = 1'b1;
            if (in_tags) begin
                r.status = irclt_pkg::ST_NO_SPACE;
            end else begin
                r.tags_found    = tag_cnt[5:0];
                r.params_found  = par_cnt[3:0];
                r.trailing_seen = trail_f;
                r.status        = ovf_f ? irclt_pkg::ST_SATURATE : irclt_pkg::ST_OK;
            end
            expected_words.push_back(r);
            ph       = irclt_pkg::PH_START;
            esc_pend = 1'b0;
            fresh    = 1'b1;
            tag_cnt  = 0;
            par_cnt  = 0;
            trail_f  = 1'b0;
            ovf_f    = 1'b0;
        end
    endtask

    function automatic logic [7:0] pick_char(input t_flavor flavor);
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 19);
        if (r == 0) c = 8'($urandom_range(0, 255));
        else if (r < 4) begin
            if (flavor == FLAVOR_VALUE) c = irclt_pkg::CH_BSLASH;
            else if (flavor == FLAVOR_TRAIL) c = irclt_pkg::CH_SPACE;
            else c = CH_DASH;
        end else if (r < 6 && flavor == FLAVOR_VALUE) begin
            case ($urandom_range(0, 3))
                0: c = irclt_pkg::CH_COLON;
                1: c = irclt_pkg::CH_S;
                2: c = irclt_pkg::CH_R;
                default: c = irclt_pkg::CH_N;
            endcase
        end else if (r < 8) c = CH_ZERO + 8'($urandom_range(0, 9));
        else if (r < 14) c = irclt_pkg::CH_LOW_A + 8'($urandom_range(0, 25));
        else c = CH_UP_A + 8'($urandom_range(0, 25));
        return c;
    endfunction

    task automatic add_line(input logic [7:0] text[$]);
        t_line_byte item;
        foreach (text[i]) begin
            item.data = text[i];
            item.eol  = (i == text.size() - 1);
            line_bytes.push_back(item);
        end
    endtask

    task automatic add_text(input string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        add_line(text);
    endtask

    // Mostly well-formed lines with random content, some plain noise.
    task automatic add_random_line();
        logic [7:0] text[$];
        int         n;
        int         len;
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 1) == 1) begin
                text.push_back(irclt_pkg::CH_AT);
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 9) == 0) text.push_back(irclt_pkg::CH_SEMI);
                    len = $urandom_range(0, 4);
                    for (int j = 0; j < len; j++) text.push_back(pick_char(FLAVOR_PLAIN));
                    if ($urandom_range(0, 2) != 0) begin
                        text.push_back(irclt_pkg::CH_EQUAL);
                        len = $urandom_range(0, 5);
                        for (int j = 0; j < len; j++) text.push_back(pick_char(FLAVOR_VALUE));
                    end
                    if (i < n - 1) text.push_back(irclt_pkg::CH_SEMI);
                end
                if ($urandom_range(0, 19) != 0) text.push_back(irclt_pkg::CH_SPACE);
            end
            if ($urandom_range(0, 2) == 0) begin
                text.push_back(irclt_pkg::CH_COLON);
                len = $urandom_range(0, 6);
                for (int j = 0; j < len; j++) text.push_back(pick_char(FLAVOR_PLAIN));
                if ($urandom_range(0, 19) != 0) text.push_back(irclt_pkg::CH_SPACE);
            end
            len = $urandom_range(1, 6);
            for (int j = 0; j < len; j++) text.push_back(pick_char(FLAVOR_PLAIN));
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(13, 18) : $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
                text.push_back(irclt_pkg::CH_SPACE);
                if ($urandom_range(0, 7) == 0) text.push_back(irclt_pkg::CH_SPACE);
                len = $urandom_range(1, 5);
                for (int j = 0; j < len; j++) text.push_back(pick_char(FLAVOR_PLAIN));
            end
            if ($urandom_range(0, 1) == 1) begin
                text.push_back(irclt_pkg::CH_SPACE);
                text.push_back(irclt_pkg::CH_COLON);
                len = $urandom_range(0, 8);
                for (int j = 0; j < len; j++) text.push_back(pick_char(FLAVOR_TRAIL));
            end
            if ($urandom_range(0, 9) == 0) begin
                text.push_back(irclt_pkg::CH_CR);
                text.push_back(irclt_pkg::CH_LF);
            end
        end
        if (text.size() == 0) text.push_back(CH_Q);
        add_line(text);
    endtask

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            errors++;
        end
    endtask

    // Sender: offers the next pending byte once the current one has been taken.
    always @(negedge clk) begin
        logic busy;
        logic quiet;
        busy  = in_valid && !in_taken;
        quiet = cycle_count >= QUIET_LO && cycle_count < QUIET_HI;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!busy) begin
            if (line_bytes.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
                in_valid <= 1'b1;
                in_byte  <= line_bytes[0].data;
                in_eol   <= line_bytes[0].eol;
                void'(line_bytes.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off that backs the block up.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && cycle_count >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !(cycle_count >= QUIET_LO && cycle_count < QUIET_HI) &&
                         $urandom_range(0, 99) < 10;
        end
    end

    // Output words are scored before this edge's input is predicted, since a word
    // cannot leave the block in the cycle its byte goes in.
    always @(posedge clk) begin
        irclt_pkg::t_result got;
        irclt_pkg::t_result want;
        cycle_count <= cycle_count + 1;
        in_taken    <= rst_n && in_valid && !in_stall;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_byte, field_kind, field_index, field_start, line_done,
                    tags_found, params_found, trailing_seen, status};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, actual byte %0d kind %0d done %0d",
                         $time, got.out_byte, got.field_kind, got.line_done);
                errors++;
            end else begin
                want = expected_words.pop_front();
                check_field("out_byte", want.out_byte, got.out_byte);
                check_field("field_kind", 8'(want.field_kind), 8'(got.field_kind));
                check_field("field_index", 8'(want.field_index), 8'(got.field_index));
                check_field("field_start", 8'(want.field_start), 8'(got.field_start));
                check_field("line_done", 8'(want.line_done), 8'(got.line_done));
                check_field("tags_found", 8'(want.tags_found), 8'(got.tags_found));
                check_field("params_found", 8'(want.params_found), 8'(got.params_found));
                check_field("trailing_seen", 8'(want.trailing_seen),
                            8'(got.trailing_seen));
                check_field("status", 8'(want.status), 8'(got.status));
            end
        end
        if (rst_n && in_valid && !in_stall) predict_words(in_byte, in_eol);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        logic [7:0] raw[$];
        // Escapes, empty entries, empty key, dangling backslash, prefix, lower-case command.
        add_text("@a=\\s\\x;;=\\ :p c m :t");
        // Dangling backslash at end of line, inside an unterminated tag block.
        add_text("@k=\\");
        // Leading space with no command, then an empty trailing parameter.
        add_text(" x :");
        // Prefix with nothing after it.
        add_text(":");
        // Extreme byte values, and an end-of-line mark on a dropped LF.
        raw = '{8'hFF, 8'h00, irclt_pkg::CH_CR, irclt_pkg::CH_LF};
        add_line(raw);
        while (line_bytes.size() < BYTE_TARGET) add_random_line();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (line_bytes.size() == 0 && !in_valid);
        wait (expected_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/irclt_pkg.sv
rtl/core/irc_line_tokenizer.sv
test/testbench.sv
